@@ rtl/rtpl_pkg.sv @@
// ----------------------------------------------------------------------------
// Route table prefix lookup package
// Shared widths, codes, types and helpers for the route table blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpl_pkg;

  // Defaults for the top-level parameters.
  localparam int ROUTES_DEF    = 32;
  localparam int ADDR_BITS_DEF = 64;

  // Fixed payload widths.
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 64;
  localparam int LEN_W    = 7;
  localparam int HOP_W    = 8;
  localparam int TYPE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 6;
  localparam int CNT_MAX  = 63;

  // Operation codes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } rtpl_op_e;

  // Status codes of a result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROUTE = 2'd1,
    ST_SELF     = 2'd2,
    ST_FULL     = 2'd3
  } rtpl_status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SORT,
    S_DONE
  } rtpl_state_e;

  // Route attributes kept next to the address in every cell.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [HOP_W-1:0]  hop;
    logic [TYPE_W-1:0] rtype;
  } rtpl_attr_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift;  // rotate: every cell loads its right neighbor
    logic sort;   // compaction pass: swap a hole with the kept entry to its right
    logic phase;  // which pairs are compared in this compaction cycle
  } rtpl_cell_ctl_t;

  // Clamp a count to the six-bit result fields.
  function automatic logic [CNT_W-1:0] sat6(input logic [15:0] v);
    logic [CNT_W-1:0] r;
    if (v > 16'(CNT_MAX)) begin
      r = CNT_W'(CNT_MAX);
    end else begin
      r = v[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rtpl_if.sv @@
// ----------------------------------------------------------------------------
// Route table channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: one item is one table operation.
interface rtpl_in_if import rtpl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  pfx_length;
  logic [HOP_W-1:0]  hop_id;
  logic [TYPE_W-1:0] route_type;
  logic              use_address;
  logic              use_length;
  logic              use_hop;
  logic              use_type;

  modport source (
    output valid, operation, address, pfx_length, hop_id, route_type,
           use_address, use_length, use_hop, use_type,
    input  ready
  );
  modport sink (
    input  valid, operation, address, pfx_length, hop_id, route_type,
           use_address, use_length, use_hop, use_type,
    output ready
  );
endinterface

// Result channel: one item per request.
interface rtpl_out_if import rtpl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HOP_W-1:0]    hop_found;
  logic [TYPE_W-1:0]   type_found;
  logic [LEN_W-1:0]    length_found;
  logic [CNT_W-1:0]    removed_count;
  logic [CNT_W-1:0]    entries_in_use;

  modport source (
    output valid, status, hop_found, type_found, length_found, removed_count,
           entries_in_use,
    input  ready
  );
  modport sink (
    input  valid, status, hop_found, type_found, length_found, removed_count,
           entries_in_use,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/route_table_prefix_lookup.sv @@
// Add and lookup make one rotation of the chain of ROUTES cells; remove makes
// one rotation, then an odd-even compaction pass. Full table, own address and
// unused codes skip the passes. One item at a time: a new item is accepted
// only once the result of the last one has been placed in the result register.
// Reset clears the route count, own address and result valid; cells hold no reset.
// ----------------------------------------------------------------------------
// Route table prefix lookup
// Ordered route table in a chain of cells with add, filtered remove with
// compaction, and longest-prefix lookup by type and length.
// ----------------------------------------------------------------------------
`default_nettype none

module route_table_prefix_lookup import rtpl_pkg::*; #(
  parameter int ROUTES    = ROUTES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rtpl_in_if.sink                in_ch,
  rtpl_out_if.source             out_ch,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_data
);

  logic [ADDR_BITS-1:0] c_addr [ROUTES];
  rtpl_attr_t           c_attr [ROUTES];
  logic                 c_hole [ROUTES];

  rtpl_cell_ctl_t       cell_ctl;
  logic [ADDR_BITS-1:0] inj_addr;
  rtpl_attr_t           inj_attr;
  logic                 inj_hole;

  // Sequencer and head evaluation.
  rtpl_ctrl #(
    .ROUTES    (ROUTES),
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .head_addr (c_addr[0]),
    .head_attr (c_attr[0]),
    .cell_ctl  (cell_ctl),
    .inj_addr  (inj_addr),
    .inj_attr  (inj_attr),
    .inj_hole  (inj_hole)
  );

  // Chain of route cells; cell 0 is the head, the tail takes the injected route.
  for (genvar i = 0; i < ROUTES; i++) begin : g_cell
    logic [ADDR_BITS-1:0] r_addr, l_addr;
    rtpl_attr_t           r_attr, l_attr;
    logic                 r_hole, l_hole;

    if (i == ROUTES - 1) begin : g_tail
      assign r_addr = inj_addr;
      assign r_attr = inj_attr;
      assign r_hole = inj_hole;
    end else begin : g_mid
      assign r_addr = c_addr[i+1];
      assign r_attr = c_attr[i+1];
      assign r_hole = c_hole[i+1];
    end

    if (i == 0) begin : g_head
      assign l_addr = '0;
      assign l_attr = '0;
      assign l_hole = 1'b0;
    end else begin : g_body
      assign l_addr = c_addr[i-1];
      assign l_attr = c_attr[i-1];
      assign l_hole = c_hole[i-1];
    end

    rtpl_cell #(
      .ADDR_BITS (ADDR_BITS),
      .PARITY    (1'(i % 2))
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl),
      .right_addr (r_addr),
      .right_attr (r_attr),
      .right_hole (r_hole),
      .left_addr  (l_addr),
      .left_attr  (l_attr),
      .left_hole  (l_hole),
      .cell_addr  (c_addr[i]),
      .cell_attr  (c_attr[i]),
      .cell_hole  (c_hole[i])
    );
  end

endmodule

`default_nettype wire

@@ rtl/rtpl_cell.sv @@
// ----------------------------------------------------------------------------
// Route table cell
// Holds one route and a hole flag; rotates toward the head or takes part in
// the odd-even compaction pass with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpl_cell import rtpl_pkg::*; #(
  parameter int   ADDR_BITS = ADDR_BITS_DEF,
  parameter logic PARITY    = 1'b0
) (
  input  wire logic                 clk,
  input  wire rtpl_cell_ctl_t       ctl,
  input  wire logic [ADDR_BITS-1:0] right_addr,
  input  wire rtpl_attr_t           right_attr,
  input  wire logic                 right_hole,
  input  wire logic [ADDR_BITS-1:0] left_addr,
  input  wire rtpl_attr_t           left_attr,
  input  wire logic                 left_hole,
  output logic [ADDR_BITS-1:0]      cell_addr,
  output rtpl_attr_t                cell_attr,
  output logic                      cell_hole
);

  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  rtpl_attr_t           attr_r, attr_nxt;
  logic                 hole_r, hole_nxt;

  // Choose the source of this cycle's content.
  always_comb begin
    addr_nxt = addr_r;
    attr_nxt = attr_r;
    hole_nxt = hole_r;
    if (ctl.shift) begin
      addr_nxt = right_addr;
      attr_nxt = right_attr;
      hole_nxt = right_hole;
    end else if (ctl.sort) begin
      if (ctl.phase == PARITY) begin
        // Left member of a pair: a hole trades places with a kept route.
        if (hole_r && !right_hole) begin
          addr_nxt = right_addr;
          attr_nxt = right_attr;
          hole_nxt = right_hole;
        end
      end else begin
        // Right member of a pair.
        if (left_hole && !hole_r) begin
          addr_nxt = left_addr;
          attr_nxt = left_attr;
          hole_nxt = left_hole;
        end
      end
    end
  end

  // Route storage has no reset; only entries below the count are ever read.
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    attr_r <= attr_nxt;
    hole_r <= hole_nxt;
  end

  assign cell_addr = addr_r;
  assign cell_attr = attr_r;
  assign cell_hole = hole_r;

endmodule

`default_nettype wire

@@ rtl/rtpl_ctrl.sv @@
// ----------------------------------------------------------------------------
// Route table controller
// Sequences each operation over the cell chain, evaluates the route at the
// head of the chain, and holds the count, own address and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpl_ctrl import rtpl_pkg::*; #(
  parameter int ROUTES    = ROUTES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rtpl_in_if.sink                   in_ch,
  rtpl_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire logic [ADDR_BITS-1:0] head_addr,
  input  wire rtpl_attr_t           head_attr,
  output rtpl_cell_ctl_t            cell_ctl,
  output logic [ADDR_BITS-1:0]      inj_addr,
  output rtpl_attr_t                inj_attr,
  output logic                      inj_hole
);

  localparam int CW = $clog2(ROUTES + 1);
  localparam int KW = $clog2(ROUTES);

  // Control state.
  rtpl_state_e          state_r, state_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [ADDR_BITS-1:0] own_r;
  logic                 out_valid_r, out_valid_nxt;

  // Working registers of the current item.
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  rtpl_attr_t           item_r, item_nxt;
  logic                 fa_r, fa_nxt, fl_r, fl_nxt, fh_r, fh_nxt, ft_r, ft_nxt;
  logic [CW-1:0]        kept_r, kept_nxt;
  logic                 have_r, have_nxt;
  rtpl_attr_t           best_r, best_nxt;
  rtpl_status_e         res_status_r, res_status_nxt;
  rtpl_attr_t           res_attr_r, res_attr_nxt;
  logic [CNT_W-1:0]     res_removed_r, res_removed_nxt;

  // Result register.
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  rtpl_attr_t           out_attr_r, out_attr_nxt;
  logic [CNT_W-1:0]     out_removed_r, out_removed_nxt;
  logic [CNT_W-1:0]     out_entries_r, out_entries_nxt;

  // Head evaluation.
  logic [ADDR_BITS-1:0] hmask;
  logic                 head_live;
  logic                 rm_match;
  logic                 lk_hit;
  logic                 lk_skip;

  // Prefix mask of the head route, most significant bits first.
  always_comb begin
    for (int j = 0; j < ADDR_BITS; j++) begin
      hmask[j] = (7'(ADDR_BITS - 1 - j) < head_attr.len);
    end
  end

  assign head_live = (CW'(k_r) < count_r);
  assign lk_hit    = (head_attr.len <= 7'(ADDR_BITS)) &&
                     (((head_addr ^ addr_r) & hmask) == '0);
  assign lk_skip   = have_r && ((head_attr.rtype > best_r.rtype) ||
                     ((head_attr.rtype == best_r.rtype) &&
                      (head_attr.len <= best_r.len)));
  assign rm_match  = (!fa_r || (head_addr == addr_r)) &&
                     (!fl_r || (head_attr.len == item_r.len)) &&
                     (!fh_r || (head_attr.hop == item_r.hop)) &&
                     (!ft_r || (head_attr.rtype == item_r.rtype));

  // Sequencer: next state, chain commands and result capture.
  always_comb begin
    state_nxt       = state_r;
    k_nxt           = k_r;
    count_nxt       = count_r;
    op_nxt          = op_r;
    addr_nxt        = addr_r;
    item_nxt        = item_r;
    fa_nxt          = fa_r;
    fl_nxt          = fl_r;
    fh_nxt          = fh_r;
    ft_nxt          = ft_r;
    kept_nxt        = kept_r;
    have_nxt        = have_r;
    best_nxt        = best_r;
    res_status_nxt  = res_status_r;
    res_attr_nxt    = res_attr_r;
    res_removed_nxt = res_removed_r;
    out_status_nxt  = out_status_r;
    out_attr_nxt    = out_attr_r;
    out_removed_nxt = out_removed_r;
    out_entries_nxt = out_entries_r;
    out_valid_nxt   = out_valid_r;
    cell_ctl        = '0;
    inj_addr        = head_addr;
    inj_attr        = head_attr;
    inj_hole        = 1'b0;

    // The consumer takes the waiting result item.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt          = in_ch.operation;
          addr_nxt        = in_ch.address[ADDR_BITS-1:0];
          item_nxt.len    = in_ch.pfx_length;
          item_nxt.hop    = in_ch.hop_id;
          item_nxt.rtype  = in_ch.route_type;
          fa_nxt          = in_ch.use_address;
          fl_nxt          = in_ch.use_length;
          fh_nxt          = in_ch.use_hop;
          ft_nxt          = in_ch.use_type;
          k_nxt           = '0;
          kept_nxt        = '0;
          have_nxt        = 1'b0;
          res_status_nxt  = ST_OK;
          res_attr_nxt    = '0;
          res_removed_nxt = '0;
          case (in_ch.operation)
            OP_ADD: begin
              if (count_r == CW'(ROUTES)) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_REMOVE: begin
              state_nxt = S_SCAN;
            end
            OP_LOOKUP: begin
              if (in_ch.address[ADDR_BITS-1:0] == own_r) begin
                res_status_nxt = ST_SELF;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // One full rotation: route k is at the head while the scan index is k.
        cell_ctl.shift = 1'b1;
        case (op_r)
          OP_ADD: begin
            if (CW'(k_r) == count_r) begin
              inj_addr = addr_r;
              inj_attr = item_r;
            end
          end
          OP_REMOVE: begin
            inj_hole = !head_live || rm_match;
            if (head_live && !rm_match) begin
              kept_nxt = kept_r + CW'(1);
            end
          end
          default: begin
            if (head_live && !lk_skip && lk_hit) begin
              have_nxt = 1'b1;
              best_nxt = head_attr;
            end
          end
        endcase
        k_nxt = k_r + KW'(1);
        if (k_r == KW'(ROUTES - 1)) begin
          k_nxt = '0;
          case (op_r)
            OP_ADD: begin
              count_nxt = count_r + CW'(1);
              state_nxt = S_DONE;
            end
            OP_REMOVE: begin
              state_nxt = S_SORT;
            end
            default: begin
              if (have_nxt) begin
                res_attr_nxt = best_nxt;
              end else begin
                res_status_nxt = ST_NO_ROUTE;
              end
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SORT: begin
        // Odd-even transposition moves kept routes ahead of the holes.
        cell_ctl.sort  = 1'b1;
        cell_ctl.phase = k_r[0];
        inj_hole       = 1'b1;
        k_nxt          = k_r + KW'(1);
        if (k_r == KW'(ROUTES - 1)) begin
          k_nxt           = '0;
          count_nxt       = kept_r;
          res_removed_nxt = sat6(16'(count_r - kept_r));
          state_nxt       = S_DONE;
        end
      end

      S_DONE: begin
        // Wait for room in the result register.
        if (!out_valid_r || out_ch.ready) begin
          out_status_nxt  = res_status_r;
          out_attr_nxt    = res_attr_r;
          out_removed_nxt = res_removed_r;
          out_entries_nxt = sat6(16'(count_r));
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      count_r     <= '0;
      own_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        own_r <= cfg_data[ADDR_BITS-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    addr_r        <= addr_nxt;
    item_r        <= item_nxt;
    fa_r          <= fa_nxt;
    fl_r          <= fl_nxt;
    fh_r          <= fh_nxt;
    ft_r          <= ft_nxt;
    kept_r        <= kept_nxt;
    have_r        <= have_nxt;
    best_r        <= best_nxt;
    res_status_r  <= res_status_nxt;
    res_attr_r    <= res_attr_nxt;
    res_removed_r <= res_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_attr_r    <= out_attr_nxt;
    out_removed_r <= out_removed_nxt;
    out_entries_r <= out_entries_nxt;
  end

  // Channel outputs.
  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.hop_found      = out_attr_r.hop;
  assign out_ch.type_found     = out_attr_r.rtype;
  assign out_ch.length_found   = out_attr_r.len;
  assign out_ch.removed_count  = out_removed_r;
  assign out_ch.entries_in_use = out_entries_r;

endmodule

`default_nettype wire
